### hdl/olad_pkg.sv
// Package for the ordered list block: request action codes, sequencer states
// and the result record passed from the core to the output register.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package olad_pkg;

	localparam logic [1:0] ACT_INSERT = 2'd0;
	localparam logic [1:0] ACT_DELETE = 2'd1;
	localparam logic [1:0] ACT_DUMP   = 2'd2;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DELETE,
		ST_DUMP,
		ST_EMPTY
	} state_t;

	typedef struct packed {
		logic signed [31:0] entry_value;
		logic               last_entry;
		logic               list_empty;
	} res_t;

endpackage

`default_nettype wire

### hdl/olad_core.sv
// Sequencer, entry memory and compare unit of the ordered list.
// Walks the memory one entry a cycle for delete requests and, unless the output stalls, for dump requests.
// Depends on olad_pkg.
`timescale 1ns / 1ps
`default_nettype none

module olad_core #(
	parameter int DEPTH = 64
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [1:0]         in_action,
	input  logic signed [31:0] in_value,
	output logic               res_valid,
	output olad_pkg::res_t     res,
	input  logic               res_ready
);
	import olad_pkg::*;

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic signed [31:0] mem [DEPTH];
	logic signed [31:0] rd_data;

	state_t             state_q, state_d;
	logic signed [31:0] val_q, val_d;
	logic [CW-1:0]      cnt_q, cnt_d;
	logic [CW-1:0]      raddr_q, raddr_d;
	logic [AW-1:0]      daddr_q, daddr_d;
	logic               dv_q, dv_d;
	logic               found_q, found_d;

	logic               issue, match, adv, rd_en, we;
	logic [AW-1:0]      waddr;
	logic signed [31:0] wdata;

	assign issue = raddr_q < cnt_q;
	assign match = rd_data == val_q;

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		if (rd_en)
			rd_data <= mem[raddr_q[AW-1:0]];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
			raddr_q <= '0;
			daddr_q <= '0;
			dv_q    <= 1'b0;
			found_q <= 1'b0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
			raddr_q <= raddr_d;
			daddr_q <= daddr_d;
			dv_q    <= dv_d;
			found_q <= found_d;
		end
	end

	always_ff @(posedge clk) begin
		val_q <= val_d;
	end

	always_comb begin
		state_d   = state_q;
		val_d     = val_q;
		cnt_d     = cnt_q;
		raddr_d   = raddr_q;
		daddr_d   = daddr_q;
		dv_d      = dv_q;
		found_d   = found_q;
		in_ready  = 1'b0;
		res_valid = 1'b0;
		res       = '0;
		rd_en     = 1'b0;
		we        = 1'b0;
		waddr     = cnt_q[AW-1:0];
		wdata     = in_value;
		adv       = !dv_q || res_ready;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				raddr_d  = '0;
				dv_d     = 1'b0;
				found_d  = 1'b0;
				if (in_valid) begin
					val_d = in_value;
					case (in_action)
						ACT_INSERT: begin
							if (cnt_q < CW'(DEPTH)) begin
								we    = 1'b1;
								cnt_d = cnt_q + CW'(1);
							end
						end
						ACT_DELETE: state_d = ST_DELETE;
						ACT_DUMP:   state_d = (cnt_q == '0) ? ST_EMPTY : ST_DUMP;
						default:    state_d = ST_IDLE;
					endcase
				end
			end
			ST_DELETE: begin
				rd_en   = issue;
				raddr_d = raddr_q + CW'(issue);
				dv_d    = issue;
				daddr_d = raddr_q[AW-1:0];
				if (dv_q) begin
					if (found_q) begin
						we    = 1'b1;
						waddr = daddr_q - AW'(1);
						wdata = rd_data;
					end else if (match) begin
						found_d = 1'b1;
					end
				end
				if (!issue && !dv_q) begin
					state_d = ST_IDLE;
					if (found_q)
						cnt_d = cnt_q - CW'(1);
				end
			end
			ST_DUMP: begin
				res_valid       = dv_q;
				res.entry_value = rd_data;
				res.last_entry  = CW'(daddr_q) == (cnt_q - CW'(1));
				if (adv) begin
					rd_en   = issue;
					raddr_d = raddr_q + CW'(issue);
					dv_d    = issue;
					daddr_d = raddr_q[AW-1:0];
					if (!issue && !dv_q)
						state_d = ST_IDLE;
				end
			end
			ST_EMPTY: begin
				res_valid      = 1'b1;
				res.last_entry = 1'b1;
				res.list_empty = 1'b1;
				if (res_ready)
					state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

endmodule

`default_nettype wire

### hdl/ordered_list_append_delete.sv
// Top level of the bounded ordered list: stream ports and output register.
// Instantiates olad_core; depends on olad_pkg.
//
// Channel | Dir | Handshake               | Payload
// s_axis  | in  | s_axis_tvalid/tready    | tdata item_value, tuser action
// m_axis  | out | m_axis_tvalid/tready    | tdata entry_value, tlast, tuser empty
//
// An insert leaves the sequencer idle and ready for the next request. A delete
// walks every entry, one memory read per entry through the single read port,
// comparing until the match is found. A dump walks every entry and is held by
// output stalls; an empty dump waits until its result is taken.
// Reset clears the entry count and the sequencer; memory contents persist.
// A stalled output holds the dump walk in place.
`timescale 1ns / 1ps
`default_nettype none

module ordered_list_append_delete #(
	parameter int DEPTH = 64
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               s_axis_tvalid,
	output logic               s_axis_tready,
	input  logic signed [31:0] s_axis_tdata,  // [31:0] item_value
	input  logic [1:0]         s_axis_tuser,  // [1:0] action
	output logic               m_axis_tvalid,
	input  logic               m_axis_tready,
	output logic signed [31:0] m_axis_tdata,  // [31:0] entry_value
	output logic               m_axis_tlast,
	output logic               m_axis_tuser   // [0] list_empty
);
	import olad_pkg::*;

	logic res_valid, res_ready;
	res_t res;
	res_t out_q;
	logic out_vld_q;

	olad_core #(
		.DEPTH(DEPTH)
	) u_core (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.in_action(s_axis_tuser),
		.in_value (s_axis_tdata),
		.res_valid(res_valid),
		.res      (res),
		.res_ready(res_ready)
	);

	assign res_ready = !out_vld_q || m_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (res_ready) begin
			out_vld_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_ready && res_valid)
			out_q <= res;
	end

	assign m_axis_tvalid = out_vld_q;
	assign m_axis_tdata  = out_q.entry_value;
	assign m_axis_tlast  = out_q.last_entry;
	assign m_axis_tuser  = out_q.list_empty;

	a_res_only_busy: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> !s_axis_tready)
		else $error("result produced while accepting requests");

	a_empty_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser |-> m_axis_tlast && (m_axis_tdata == 32'sd0))
		else $error("empty dump result malformed");

	a_insert_one_cycle: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready && (s_axis_tuser == ACT_INSERT) |=> s_axis_tready)
		else $error("insert did not complete in one cycle");

endmodule

`default_nettype wire
